// File: src/stf_pkg.sv
package stf_pkg;

	// default number of series terms, first term included
	localparam int TERMS_DEF = 8;

	// number of stored reciprocals, so at most this many terms after the first
	localparam int NRECIP = 11;

	// compare and subtract steps of the range reduction; the quotient of
	// 2^63 by two pi stays below 2^5
	localparam int RED_STEPS = 5;

	// angle constants, unsigned Q.56, rounded to nearest
	localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
	localparam logic [63:0] PI_Q56      = 64'h03243F6A8885A309;
	localparam logic [63:0] TPH_PI_Q56  = 64'h04B65F1FCCC8748D;
	localparam logic [63:0] TWO_PI_Q56  = 64'h06487ED5110B4612;

	localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;
	localparam logic [63:0] HALF_Q60 = 64'h0800_0000_0000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;
	localparam logic [33:0] ONE_Q30  = 34'h0_4000_0000;

	// 1/((2k)(2k+1)) in Q.60, rounded to nearest, k = 1 .. NRECIP
	localparam logic [63:0] RECIP_TAB [NRECIP] = '{
		(ONE_Q60 + 64'd3)   / 64'd6,
		(ONE_Q60 + 64'd10)  / 64'd20,
		(ONE_Q60 + 64'd21)  / 64'd42,
		(ONE_Q60 + 64'd36)  / 64'd72,
		(ONE_Q60 + 64'd55)  / 64'd110,
		(ONE_Q60 + 64'd78)  / 64'd156,
		(ONE_Q60 + 64'd105) / 64'd210,
		(ONE_Q60 + 64'd136) / 64'd272,
		(ONE_Q60 + 64'd171) / 64'd342,
		(ONE_Q60 + 64'd210) / 64'd420,
		(ONE_Q60 + 64'd253) / 64'd506
	};

	// folded first-quadrant angle, Q.60
	typedef struct packed {
		logic [63:0] x;
		logic        neg;
		logic        bad;
	} fold_t;

	// running state of the series
	typedef struct packed {
		logic [63:0] x2;
		logic [63:0] trm;
		logic [63:0] acc;
		logic        neg;
		logic        bad;
	} series_t;

endpackage

// File: src/stf_in_if.sv
interface stf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angle;
	logic               angle_invalid;

	modport source (output valid, angle, angle_invalid, input ready);
	modport sink (input valid, angle, angle_invalid, output ready);
endinterface

// File: src/stf_out_if.sv
interface stf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sine;
	logic               result_invalid;

	modport source (output valid, sine, result_invalid, input ready);
	modport sink (input valid, sine, result_invalid, output ready);
endinterface

// File: src/stf_reduce.sv
module stf_reduce (
	input  logic            clk,
	input  logic            arst_n,
	stf_in_if.sink          angle_ch,
	output logic            out_valid,
	input  logic            out_ready,
	output stf_pkg::fold_t  out_data
);

	localparam int RS = stf_pkg::RED_STEPS;
	localparam int NS = RS + 2;

	typedef struct packed {
		logic [63:0] rem;
		logic        neg;
		logic        bad;
	} red_t;

	logic [NS-1:0]  v_s;
	logic [NS-1:0]  v_in;
	logic [NS:0]    rdy;
	red_t           red_w [RS+1];
	stf_pkg::fold_t fold_s1;
	stf_pkg::fold_t fold_d;

	// bubble-collapsing ready chain
	assign rdy[NS] = out_ready;
	for (genvar j = 0; j < NS; j++) begin : g_rdy
		assign rdy[j] = !v_s[j] || rdy[j+1];
	end
	assign v_in = {v_s[NS-2:0], angle_ch.valid};
	assign angle_ch.ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int j = 0; j < NS; j++) begin
				if (rdy[j]) begin
					v_s[j] <= v_in[j];
				end
			end
		end
	end

	for (genvar j = 0; j <= RS; j++) begin : g_stage
		red_t st_s;
		assign red_w[j] = st_s;
		if (j == 0) begin : g_load
			logic [31:0] mag;
			// the most negative angle negates to 2^31, which is its magnitude
			assign mag = angle_ch.angle[31] ? (~angle_ch.angle + 32'd1) : angle_ch.angle;
			always_ff @(posedge clk) begin
				if (rdy[0]) begin
					st_s <= '{rem: {mag, 32'd0}, neg: angle_ch.angle[31],
						bad: angle_ch.angle_invalid};
				end
			end
		end else begin : g_sub
			localparam logic [63:0] SUB = stf_pkg::TWO_PI_Q56 << (RS - j);
			red_t nxt;
			always_comb begin
				nxt = red_w[j-1];
				if (red_w[j-1].rem >= SUB) begin
					nxt.rem = red_w[j-1].rem - SUB;
				end
			end
			always_ff @(posedge clk) begin
				if (rdy[j]) begin
					st_s <= nxt;
				end
			end
		end
	end

	// fold into the first quadrant
	always_comb begin
		logic [63:0] r;
		logic        n;
		r = red_w[RS].rem;
		n = red_w[RS].neg;
		if (r > stf_pkg::HALF_PI_Q56 && r <= stf_pkg::PI_Q56) begin
			r = stf_pkg::PI_Q56 - red_w[RS].rem;
		end else if (r > stf_pkg::PI_Q56 && r <= stf_pkg::TPH_PI_Q56) begin
			r = red_w[RS].rem - stf_pkg::PI_Q56;
			n = !n;
		end else if (r > stf_pkg::TPH_PI_Q56) begin
			r = stf_pkg::TWO_PI_Q56 - red_w[RS].rem;
			n = !n;
		end
		fold_d = '{x: r << 4, neg: n, bad: red_w[RS].bad};
	end

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			fold_s1 <= fold_d;
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_data  = fold_s1;

endmodule

// File: src/stf_mul.sv
module stf_mul #(
	parameter type side_t = logic
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  side_t       in_side,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] p,
	output side_t       out_side
);

	logic         v_s1, v_s2;
	logic         rdy1, rdy2;
	logic [63:0]  ll_s1, lh_s1, hl_s1, hh_s1;
	side_t        side_s1, side_s2;
	logic [63:0]  p_s2;
	logic [127:0] full;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// four 32x32 partial products
	always_ff @(posedge clk) begin
		if (rdy1) begin
			ll_s1   <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
			lh_s1   <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
			hl_s1   <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
			hh_s1   <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
			side_s1 <= in_side;
		end
	end

	// sum, round half up at bit 59, keep bits 123:60
	assign full = {hh_s1, ll_s1} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
		+ {64'd0, stf_pkg::HALF_Q60};

	always_ff @(posedge clk) begin
		if (rdy2) begin
			p_s2    <= full[123:60];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign p         = p_s2;
	assign out_side  = side_s2;

endmodule

// File: src/stf_term.sv
module stf_term #(
	parameter int K = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stf_pkg::series_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output stf_pkg::series_t  out_data
);

	localparam bit SUBTRACT = (K % 2) == 1;
	localparam logic [63:0] RECIP = stf_pkg::RECIP_TAB[K-1];

	logic             v1, v2, rdy2, rdy3;
	logic [63:0]      p1, p2;
	stf_pkg::series_t side1, side2;
	stf_pkg::series_t ser_d;
	stf_pkg::series_t ser_s1;
	logic             v_s1;

	// term times x squared
	stf_mul #(.side_t(stf_pkg::series_t)) u_mul_x2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a         (in_data.trm),
		.b         (in_data.x2),
		.in_side   (in_data),
		.out_valid (v1),
		.out_ready (rdy2),
		.p         (p1),
		.out_side  (side1)
	);

	// times the reciprocal of (2k)(2k+1)
	stf_mul #(.side_t(stf_pkg::series_t)) u_mul_rc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (rdy2),
		.a         (p1),
		.b         (RECIP),
		.in_side   (side1),
		.out_valid (v2),
		.out_ready (rdy3),
		.p         (p2),
		.out_side  (side2)
	);

	assign rdy3 = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy3) begin
			v_s1 <= v2;
		end
	end

	// alternating sign, modulo 2^64
	always_comb begin
		ser_d     = side2;
		ser_d.trm = p2;
		ser_d.acc = SUBTRACT ? (side2.acc - p2) : (side2.acc + p2);
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			ser_s1 <= ser_d;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = ser_s1;

endmodule

// File: src/stf_round.sv
module stf_round (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  stf_pkg::series_t in_data,
	stf_out_if.source        res_ch
);

	logic        v_s1, v_s2, rdy1, rdy2;
	logic [63:0] rsum;
	logic [33:0] rq;
	logic [30:0] mag_s1;
	logic        neg_s1, bad_s1;
	logic [31:0] mag32;
	logic [31:0] sine_s2;
	logic        bad_s2;

	assign rdy2     = !v_s2 || res_ch.ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// round to Q1.30, tie up, then clamp to one
	assign rsum = in_data.acc + stf_pkg::HALF_Q30;
	assign rq   = rsum[63:30];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mag_s1 <= (rq > stf_pkg::ONE_Q30) ? stf_pkg::ONE_Q30[30:0] : rq[30:0];
			neg_s1 <= in_data.neg;
			bad_s1 <= in_data.bad;
		end
	end

	assign mag32 = {1'b0, mag_s1};

	always_ff @(posedge clk) begin
		if (rdy2) begin
			if (bad_s1) begin
				sine_s2 <= '0;
			end else begin
				sine_s2 <= neg_s1 ? (~mag32 + 32'd1) : mag32;
			end
			bad_s2 <= bad_s1;
		end
	end

	assign res_ch.valid          = v_s2;
	assign res_ch.sine           = sine_s2;
	assign res_ch.result_invalid = bad_s2;

endmodule

// File: src/sine_taylor_fixed_top.sv
// throughput: one angle per cycle while the output is not held, set by the fully pipelined 64x64 multipliers
// a stalled output holds its beat while bubbles further back keep filling
// reset: arst_n clears every valid bit at once; no payload register is reset
// no clearing pass, the block takes beats in the first cycle after reset
module sine_taylor_fixed_top #(
	parameter int TERMS = stf_pkg::TERMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stf_in_if.sink    angle_ch,
	stf_out_if.source sine_ch
);

	// terms after the first, capped by the reciprocal table
	localparam int NSTEP = (TERMS - 1 < stf_pkg::NRECIP) ? TERMS - 1 : stf_pkg::NRECIP;

	// reduction to fold
	logic             fold_valid, fold_ready;
	stf_pkg::fold_t   fold_data;

	// x squared with the folded angle riding along
	logic             sq_valid;
	logic [63:0]      x2;
	stf_pkg::fold_t   sq_side;

	// series chain, element 0 is the first term x itself
	stf_pkg::series_t ser [NSTEP+1];
	logic [NSTEP:0]   ser_v;
	logic [NSTEP:0]   ser_rdy;

	// magnitude, five compare and subtract steps against 16, 8, 4, 2, 1 times
	// two pi, then the quadrant fold; seven register stages
	stf_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle_ch  (angle_ch),
		.out_valid (fold_valid),
		.out_ready (fold_ready),
		.out_data  (fold_data)
	);

	// x^2 in Q.60, two stages: partial products, then rounded sum
	stf_mul #(.side_t(stf_pkg::fold_t)) u_mul_sq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fold_valid),
		.in_ready  (fold_ready),
		.a         (fold_data.x),
		.b         (fold_data.x),
		.in_side   (fold_data),
		.out_valid (sq_valid),
		.out_ready (ser_rdy[0]),
		.p         (x2),
		.out_side  (sq_side)
	);

	// seed the series: term and sum both start at x
	assign ser[0]   = '{x2: x2, trm: sq_side.x, acc: sq_side.x,
		neg: sq_side.neg, bad: sq_side.bad};
	assign ser_v[0] = sq_valid;

	// one five-stage section per term: two multiplies and the accumulate
	for (genvar k = 1; k <= NSTEP; k++) begin : g_term
		stf_term #(.K(k)) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ser_v[k-1]),
			.in_ready  (ser_rdy[k-1]),
			.in_data   (ser[k-1]),
			.out_valid (ser_v[k]),
			.out_ready (ser_rdy[k]),
			.out_data  (ser[k])
		);
	end

	// rounding, clamp and sign in two stages; the last one is the output register
	stf_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ser_v[NSTEP]),
		.in_ready (ser_rdy[NSTEP]),
		.in_data  (ser[NSTEP]),
		.res_ch   (sine_ch)
	);

	// an invalid input always leaves as a zero sine
	assert property (@(posedge clk) disable iff (!arst_n)
		sine_ch.valid && sine_ch.result_invalid |-> sine_ch.sine == 32'sd0)
		else $error("invalid beat with non-zero sine");

	// the clamp keeps every result within plus or minus one
	assert property (@(posedge clk) disable iff (!arst_n)
		sine_ch.valid |-> ($signed(sine_ch.sine) <= 32'sd1073741824)
			&& ($signed(sine_ch.sine) >= -32'sd1073741824))
		else $error("sine beyond plus or minus one");

	// input is refused only when every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!angle_ch.ready |-> sine_ch.valid && !sine_ch.ready)
		else $error("input stalled while the pipeline can move");

	// a held result beat keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		sine_ch.valid && !sine_ch.ready |=> $stable(sine_ch.sine)
			&& $stable(sine_ch.result_invalid))
		else $error("held result beat changed");

endmodule
